@@ hw/rtl/lru_capped_active_set_unit_macros.svh @@
// ---------------------------------------------------------------------------
// lru_capped_active_set_unit_macros.svh
// Assertion shorthands shared by the active-set checker.
// ---------------------------------------------------------------------------
`ifndef LRU_CAPPED_ACTIVE_SET_UNIT_MACROS_SVH
`define LRU_CAPPED_ACTIVE_SET_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LCAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcas check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LCAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcas check failed");

`endif

@@ hw/rtl/lcas_pkg.sv @@
// ---------------------------------------------------------------------------
// lcas_pkg
// Shared widths, codes and types of the capped LRU active-set unit.
// ---------------------------------------------------------------------------
package lcas_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int ID_W       = 32;
  localparam int CMD_W      = 2;
  localparam int ACT_W      = 2;
  localparam int COUNT_W    = 6;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_DATA_W = ACT_W + ID_W + COUNT_W;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_SHOW = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HIDE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  // Result actions
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_HIDE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SHOW = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP  = 2'd2;

  // Mode values
  localparam logic MODE_EXCL  = 1'b0;
  localparam logic MODE_LIMIT = 1'b1;

  // Per-cell update command
  typedef struct packed {
    logic shift;  // take id from the cell above
    logic load;   // take the broadcast id, become valid
    logic clr;    // become invalid
  } cell_ctl_t;

endpackage

@@ hw/rtl/lcas_cell.sv @@
// ---------------------------------------------------------------------------
// lcas_cell
// One slot of the recency chain: holds an id and its valid bit, compares
// against the lookup key and shifts down from its upper neighbor.
// ---------------------------------------------------------------------------
module lcas_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcas_pkg::cell_ctl_t    ctl,
  input  logic [lcas_pkg::ID_W-1:0] up_id,
  input  logic [lcas_pkg::ID_W-1:0] wr_id,
  input  logic [lcas_pkg::ID_W-1:0] key,
  output logic [lcas_pkg::ID_W-1:0] id,
  output logic                   hit
);
  import lcas_pkg::*;

  logic [ID_W-1:0] id_r;
  logic            valid_r;

  // Valid bit: load wins over clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= 1'b1;
    end else if (ctl.clr) begin
      valid_r <= 1'b0;
    end
  end

  // Id payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_r <= wr_id;
    end else if (ctl.shift) begin
      id_r <= up_id;
    end
  end

  assign id    = id_r;
  assign hit   = valid_r && (id_r == key);

endmodule

@@ hw/rtl/lcas_ctrl.sv @@
// ---------------------------------------------------------------------------
// lcas_ctrl
// Sequencer of the active-set unit: takes requests, drives the cell chain
// and produces result beats one at a time into the output register.
// ---------------------------------------------------------------------------
module lcas_ctrl (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request side
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [lcas_pkg::CMD_W-1:0]             in_cmd,
  input  logic [lcas_pkg::ID_W-1:0]              in_id,
  // result side
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [lcas_pkg::ACT_W-1:0]             out_action,
  output logic [lcas_pkg::ID_W-1:0]              out_target,
  output logic [lcas_pkg::COUNT_W-1:0]           out_count,
  output logic                                   out_last,
  // configuration
  input  logic                                   cfg_we,
  input  logic [lcas_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [lcas_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // cell chain
  input  logic [lcas_pkg::TABLE_DEPTH-1:0]       cell_hit,
  input  logic [lcas_pkg::ID_W-1:0]              bottom_id,
  output logic [lcas_pkg::ID_W-1:0]              key,
  output lcas_pkg::cell_ctl_t [lcas_pkg::TABLE_DEPTH-1:0] cell_ctl
);
  import lcas_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_APPLY, S_EVICT} state_t;

  state_t                 state_r, state_nxt;
  logic [CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [ID_W-1:0]        key_r, key_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [ID_W-1:0]        restore_r, restore_nxt;
  logic [TABLE_DEPTH-1:0] hit_r, hit_nxt;
  logic                   mode_r;
  logic [LIMIT_W-1:0]     limit_r;
  logic                   keep_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]       out_action_r, out_action_nxt;
  logic [ID_W-1:0]        out_target_r, out_target_nxt;
  logic [CNT_W-1:0]       out_count_r, out_count_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   out_free;
  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic [CNT_W-1:0]       lim;
  logic                   touch_op, hide_op;
  logic                   rem_en, ld_en;
  logic [IDX_W-1:0]       rem_idx;
  logic [CNT_W-1:0]       ld_pos;
  logic [CNT_W-1:0]       count_dec;

  // Encode the one matching slot (ids are unique in the table)
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_r[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  assign found     = |hit_r;
  assign out_free  = !out_valid_r || out_tready;
  assign count_dec = count_r - CNT_W'(1);
  assign touch_op  = (key_r != '0) && ((cmd_r == CMD_SHOW) || (cmd_r == CMD_TICK));
  assign hide_op   = (key_r != '0) && (cmd_r == CMD_HIDE);

  // Active cap: exclusive keeps one, a zero limit acts as one
  always_comb begin
    if (mode_r == MODE_LIMIT && limit_r != '0) begin
      lim = CNT_W'(limit_r);
    end else begin
      lim = CNT_W'(1);
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    restore_nxt    = restore_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_action_nxt = out_action_r;
    out_target_nxt = out_target_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    rem_en         = 1'b0;
    rem_idx        = '0;
    ld_en          = 1'b0;
    ld_pos         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          key_nxt   = (in_cmd == CMD_TICK) ? restore_r : in_id;
          state_nxt = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        hit_nxt   = cell_hit;
        state_nxt = S_APPLY;
      end

      S_APPLY: begin
        if (out_free) begin
          // default: single no-action result
          out_valid_nxt  = 1'b1;
          out_action_nxt = ACT_NONE;
          out_target_nxt = '0;
          out_count_nxt  = count_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;

          if (touch_op) begin
            ld_en = 1'b1;
            if (found) begin
              // refresh: pull it out, put it back on top
              rem_en  = 1'b1;
              rem_idx = hit_idx;
              ld_pos  = count_dec;
            end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
              // full: drop least recent
              rem_en  = 1'b1;
              ld_pos  = CNT_W'(TABLE_DEPTH - 1);
            end else begin
              ld_pos    = count_r;
              count_nxt = count_r + CNT_W'(1);
            end

            if (cmd_r == CMD_TICK) begin
              restore_nxt    = '0;
              out_action_nxt = ACT_SHOW;
              out_target_nxt = key_r;
              out_count_nxt  = count_nxt;
            end else begin
              out_valid_nxt = out_valid_r && !out_tready;
              state_nxt     = S_EVICT;
            end
          end else if (hide_op) begin
            if (found) begin
              rem_en    = 1'b1;
              rem_idx   = hit_idx;
              count_nxt = count_dec;
            end
            out_count_nxt = count_nxt;
            if (keep_r && count_nxt == '0) begin
              restore_nxt = key_r;
            end
          end
        end
      end

      S_EVICT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (count_r > lim) begin
            // hide least recent
            rem_en         = 1'b1;
            count_nxt      = count_dec;
            out_action_nxt = ACT_HIDE;
            out_target_nxt = bottom_id;
            out_count_nxt  = count_dec;
            out_last_nxt   = (count_dec == lim);
            if (count_dec == lim) state_nxt = S_IDLE;
          end else begin
            out_action_nxt = ACT_NONE;
            out_target_nxt = '0;
            out_count_nxt  = count_r;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Per-cell commands: remove shifts the upper part down, load writes on top
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_ctl[i].shift = rem_en && (IDX_W'(i) >= rem_idx) &&
                          ((CNT_W'(i) + CNT_W'(1)) < count_r);
      cell_ctl[i].clr   = rem_en && ((CNT_W'(i) + CNT_W'(1)) == count_r);
      cell_ctl[i].load  = ld_en && (CNT_W'(i) == ld_pos);
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      restore_r   <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_EXCL;
      limit_r     <= LIMIT_W'(2);
      keep_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      restore_r   <= restore_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MODE:  mode_r  <= cfg_wdata[0];
          CFG_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
          CFG_KEEP:  keep_r  <= cfg_wdata[0];
          default:   ;
        endcase
      end
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    hit_r        <= hit_nxt;
    out_action_r <= out_action_nxt;
    out_target_r <= out_target_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign key        = key_r;
  assign out_tvalid = out_valid_r;
  assign out_action = out_action_r;
  assign out_target = out_target_r;
  assign out_count  = COUNT_W'(out_count_r);
  assign out_last   = out_last_r;

endmodule

@@ hw/rtl/lru_capped_active_set_unit.sv @@
// The unit keeps up to 32 active ids in recency order in a chain of slot
// cells, least recent at the bottom. A request is taken only when the
// sequencer is idle; it then goes through the key compare in all cells
// (S_LOOKUP), the step applying the show, hide or tick (S_APPLY), and for
// a show the evict step (S_EVICT), which emits one hide per evicted id (a
// single no-action result when nothing is evicted), each eviction shifting
// the occupied part of the chain down by one slot. The apply and evict
// steps wait while the result side stalls.
// The next request is taken while the final result still sits in the
// output register.
// ---------------------------------------------------------------------------
// lru_capped_active_set_unit
// Capped LRU active-id set: show/hide/tick requests in, hide/show/no-action
// results out, with optional restore of the last hidden id.
// ---------------------------------------------------------------------------
module lru_capped_active_set_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lcas_pkg::ID_W-1:0]            in_tdata,   // [31:0] item_id
  input  logic [lcas_pkg::CMD_W-1:0]           in_tuser,   // [1:0] command
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lcas_pkg::OUT_DATA_W-1:0]      out_tdata,  // [1:0] action,
                                                           // [33:2] dest_id,
                                                           // [39:34] active_count
  output logic                                 out_tlast,
  // configuration
  input  logic                                 cfg_we,
  input  logic [lcas_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [lcas_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lcas_pkg::*;

  logic [TABLE_DEPTH-1:0]           cell_hit;
  logic [TABLE_DEPTH-1:0][ID_W-1:0] cell_id;
  logic [TABLE_DEPTH-1:0][ID_W-1:0] cell_up;
  cell_ctl_t [TABLE_DEPTH-1:0]      cell_ctl;
  logic [ID_W-1:0]                  key;
  logic [ACT_W-1:0]                 out_action;
  logic [ID_W-1:0]                  out_target;
  logic [COUNT_W-1:0]               out_count;

  // Sequencer
  lcas_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .in_id      (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_action (out_action),
    .out_target (out_target),
    .out_count  (out_count),
    .out_last   (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .cell_hit   (cell_hit),
    .bottom_id  (cell_id[0]),
    .key        (key),
    .cell_ctl   (cell_ctl)
  );

  // Chain of slot cells; the top cell has nothing above it
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == TABLE_DEPTH - 1) begin : g_top
      assign cell_up[g] = '0;
    end else begin : g_mid
      assign cell_up[g] = cell_id[g+1];
    end

    lcas_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl[g]),
      .up_id (cell_up[g]),
      .wr_id (key),
      .key   (key),
      .id    (cell_id[g]),
      .hit   (cell_hit[g])
    );
  end

  assign out_tdata = {out_count, out_target, out_action};

endmodule

@@ hw/rtl/lcas_checker.sv @@
// ---------------------------------------------------------------------------
// lcas_checker
// Port-level checks of the active-set unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "lru_capped_active_set_unit_macros.svh"

module lcas_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [lcas_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                                out_tlast
);
  import lcas_pkg::*;

  logic [ACT_W-1:0]   act;
  logic [ID_W-1:0]    tgt;
  logic [COUNT_W-1:0] cnt;

  assign act = out_tdata[ACT_W-1:0];
  assign tgt = out_tdata[ACT_W+ID_W-1:ACT_W];
  assign cnt = out_tdata[OUT_DATA_W-1:ACT_W+ID_W];

  // a stalled result stays offered
  `LCAS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // a no-action result is alone and names no id
  `LCAS_ASSERT_IMP(a_none_alone, out_tvalid && act == ACT_NONE, tgt == '0 && out_tlast)
  // a restore show is the only result and leaves at least one active
  `LCAS_ASSERT_IMP(a_show_last, out_tvalid && act == ACT_SHOW, out_tlast && cnt != '0)
  // count fits the table and the action code is a known one
  `LCAS_ASSERT_IMP(a_count_range, out_tvalid,
    cnt <= COUNT_W'(TABLE_DEPTH) && (act == ACT_NONE || act == ACT_HIDE || act == ACT_SHOW))

endmodule

bind lru_capped_active_set_unit lcas_checker u_lcas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the capped LRU active-set unit. Show, hide, tick
// and unused-command requests go in over the request stream, with random
// source gaps and sink stalls. A behavioral copy of the recency table
// predicts every hide/show/no-action result, and each result is checked
// field by field. Settings change between phases, and only after the unit
// has drained.
// ---------------------------------------------------------------------------
module tb;
  import lcas_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;  // cycles with no handshake on either side
  localparam int TAIL_WAIT  = 40;    // tail to watch for stray results after the drain

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [ID_W-1:0]    target;
    logic [COUNT_W-1:0] count;
    logic               last;
  } lru_result_t;

  // Recency table predictor and result checker
  class lru_scoreboard;
    logic [ID_W-1:0]    recency_q[$];  // entry 0 is the least recent
    logic [ID_W-1:0]    restore_id;
    logic               mode;
    logic [LIMIT_W-1:0] limit;
    logic               keep_one;
    lru_result_t        expected_q[$];
    int                 errors;

    function new();
      restore_id = '0;
      mode       = MODE_EXCL;
      limit      = 5'd2;
      keep_one   = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int find_slot(input logic [ID_W-1:0] id);
      foreach (recency_q[i])
        if (recency_q[i] == id) return i;
      return -1;
    endfunction

    // move id to most recent; a full table drops its least recent entry
    function void touch(input logic [ID_W-1:0] id);
      int hit;
      hit = find_slot(id);
      if (hit >= 0) recency_q.delete(hit);
      else if (recency_q.size() >= TABLE_DEPTH) recency_q.delete(0);
      recency_q.push_back(id);
    endfunction

    function void push_result(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id);
      lru_result_t r;
      r.action = act;
      r.target = id;
      r.count  = COUNT_W'(recency_q.size());
      r.last   = 1'b0;
      expected_q.push_back(r);
    endfunction

    // accepted request: update the table and queue its results
    function void note_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
      int base;
      int cap;
      int hit;
      base = expected_q.size();
      if (cmd == CMD_SHOW && id != '0) begin
        touch(id);
        cap = (mode == MODE_EXCL) ? 1 : ((limit == 0) ? 1 : limit);
        while (recency_q.size() > cap)
          push_result(ACT_HIDE, recency_q.pop_front());
      end else if (cmd == CMD_HIDE && id != '0) begin
        hit = find_slot(id);
        if (hit >= 0) recency_q.delete(hit);
        // arms even when the id was not active
        if (keep_one && recency_q.size() == 0) restore_id = id;
      end else if (cmd == CMD_TICK && restore_id != '0) begin
        touch(restore_id);  // no eviction on restore
        push_result(ACT_SHOW, restore_id);
        restore_id = '0;
      end
      if (expected_q.size() == base) push_result(ACT_NONE, '0);
      expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] tgt,
                      input logic [COUNT_W-1:0] cnt, input logic lst);
      lru_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result action=%0d id=%h count=%0d", act, tgt, cnt));
      end else begin
        e = expected_q.pop_front();
        if (act !== e.action)
          report($sformatf("action %0d, want %0d (id %h)", act, e.action, e.target));
        if (tgt !== e.target)
          report($sformatf("dest_id %h, want %h", tgt, e.target));
        if (cnt !== e.count)
          report($sformatf("active_count %0d, want %0d (id %h)", cnt, e.count, e.target));
        if (lst !== e.last)
          report($sformatf("last %0b, want %0b (id %h)", lst, e.last, e.target));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [ID_W-1:0]       in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lru_scoreboard sb = new();
  bit            calm = 1'b0;  // no gaps or stalls while set
  int            idle_cycles = 0;

  lru_capped_active_set_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sink: random stalls, about one cycle in four
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 25);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[ACT_W-1:0], out_tdata[ACT_W +: ID_W],
                      out_tdata[ACT_W+ID_W +: COUNT_W], out_tlast);
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("lru_capped_active_set_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One request, after a random source gap
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= id;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, id);
  endtask

  // Hold the source until every queued result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Writes all three registers; only called with the unit drained
  task automatic set_config(input logic m, input logic [LIMIT_W-1:0] lim, input logic k);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MODE;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, m};
    @(posedge clk);
    cfg_idx   <= CFG_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_idx   <= CFG_KEEP;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, k};
    @(posedge clk);
    cfg_we      <= 1'b0;
    sb.mode     = m;
    sb.limit    = lim;
    sb.keep_one = k;
  endtask

  // Mostly a small id pool so ids recur; some full-width ids and some zero
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return $urandom;
    return $urandom_range(1, 40);
  endfunction

  // Random request mix; counted is low for requests the unit just ignores
  task automatic random_request(output bit counted);
    int r;
    logic [ID_W-1:0] id;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (sb.keep_one && r < 8) begin
      // empty the set, then restore on a tick
      do begin
        send(CMD_HIDE, (sb.recency_q.size() > 0) ? sb.recency_q[0]
                                                  : ID_W'($urandom_range(1, 40)));
      end while (sb.recency_q.size() > 0);
      send(CMD_TICK, $urandom);
    end else if (r < 55) begin
      id = pick_id();
      counted = (id != '0);
      send(CMD_SHOW, id);
    end else if (r < 80) begin
      if (sb.recency_q.size() > 0 && $urandom_range(0, 99) < 70)
        id = sb.recency_q[$urandom_range(0, sb.recency_q.size() - 1)];
      else
        id = pick_id();
      counted = (id != '0);
      send(CMD_HIDE, id);
    end else if (r < 95) begin
      counted = (sb.restore_id != '0);
      send(CMD_TICK, $urandom);
    end else begin
      counted = 1'b0;
      send(CMD_UNUSED, $urandom);
    end
  endtask

  task automatic run_phase(input int n_items);
    int done;
    bit counted;
    done = 0;
    while (done < n_items) begin
      random_request(counted);
      if (counted) done++;
    end
    drain();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_SHOW;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_MODE;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero id, unused command, idle tick, widest id, refresh
    send(CMD_SHOW, '0);
    send(CMD_HIDE, '0);
    send(CMD_TICK, '1);
    send(CMD_UNUSED, 32'd5);
    send(CMD_SHOW, '1);
    send(CMD_SHOW, 32'd1);
    send(CMD_SHOW, 32'd1);
    send(CMD_HIDE, 32'd2);
    send(CMD_HIDE, 32'd1);
    drain();

    // Directed: restore armed by the last hide, kept over a show
    set_config(MODE_EXCL, 5'd2, 1'b1);
    send(CMD_SHOW, 32'd3);
    send(CMD_HIDE, 32'd3);
    send(CMD_SHOW, 32'd4);
    send(CMD_TICK, '0);
    send(CMD_TICK, '0);
    send(CMD_HIDE, 32'd9);
    send(CMD_HIDE, 32'd4);
    send(CMD_HIDE, 32'd3);
    send(CMD_HIDE, 32'd7);   // inactive id while empty still arms
    send(CMD_TICK, '0);
    drain();

    // Directed: zero limit behaves as one, then a small limit
    set_config(MODE_LIMIT, 5'd0, 1'b0);
    send(CMD_SHOW, 32'd10);
    send(CMD_SHOW, 32'd11);
    drain();
    set_config(MODE_LIMIT, 5'd3, 1'b0);
    send(CMD_SHOW, 32'd12);
    send(CMD_SHOW, 32'd13);
    send(CMD_SHOW, 32'd14);
    send(CMD_SHOW, 32'h8000_0001);
    drain();

    // Random phases
    set_config(MODE_EXCL, 5'd2, 1'b0);
    run_phase(15);
    set_config(MODE_LIMIT, 5'd5, 1'b1);
    run_phase(20);

    // Fill to the widest limit, restore on top for a full table, then overflow
    set_config(MODE_LIMIT, 5'd31, 1'b1);
    do begin
      send(CMD_HIDE, (sb.recency_q.size() > 0) ? sb.recency_q[0] : ID_W'($urandom | 1));
    end while (sb.recency_q.size() > 0);
    repeat (31) send(CMD_SHOW, $urandom | 1);
    send(CMD_TICK, '0);
    send(CMD_SHOW, $urandom | 1);
    drain();

    // Long stretch with neither gaps nor stalls
    set_config(MODE_LIMIT, 5'd31, 1'b0);
    calm = 1'b1;
    run_phase(20);
    calm = 1'b0;

    // Exclusive after a crowded set: long runs of hides
    set_config(MODE_EXCL, 5'd1, 1'b1);
    run_phase(15);
    set_config(MODE_LIMIT, 5'd0, 1'b1);
    run_phase(10);
    set_config(MODE_LIMIT, 5'($urandom_range(1, 20)), 1'($urandom_range(0, 1)));
    run_phase(15);

    // Wait out the tail, watching for stray results
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lru_capped_active_set_unit: match");
    end else begin
      $display("lru_capped_active_set_unit: mismatch");
    end
    $finish;
  end

endmodule
